FILE: rtl/rba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rba_pkg
// Shared types and constants for the relative bearing angle pipeline: the
// CSR register map, the per-stage control group and the arctangent table.
// ----------------------------------------------------------------------------
package rba_pkg;

   // CSR register map
   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_POS_X   = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_POS_Z   = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_HEADING = 2'd2;

   // Angle accumulator: unsigned, 2^32 per turn
   localparam int ACC_BITS = 32;
   localparam logic [ACC_BITS-1:0] HALF_TURN = 32'h8000_0000;

   // atan(2^-i) in accumulator units, truncated
   localparam int ATAN_ENTRIES = 24;
   localparam logic [ACC_BITS-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   // Control group that travels with each pipeline stage
   typedef struct packed {
      logic valid;   // stage holds a transaction
      logic zero;    // target equals position
   } rba_ctrl_type;

endpackage
`default_nettype wire

FILE: rtl/rba_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rba_front
// Two pipeline stages: offset from the position, then fold into the right
// half plane with a half-turn preset of the angle accumulator.
// ----------------------------------------------------------------------------
module rba_front #(
   parameter int COORD_BITS = 32,
   parameter int W          = 35
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic                           in_valid,
   input  wire logic signed [COORD_BITS-1:0]   target_x,
   input  wire logic signed [COORD_BITS-1:0]   target_z,
   input  wire logic signed [COORD_BITS-1:0]   pos_x,
   input  wire logic signed [COORD_BITS-1:0]   pos_z,
   output rba_pkg::rba_ctrl_type               ctrl_out,
   output logic signed [W-1:0]                 x_out,
   output logic signed [W-1:0]                 z_out,
   output logic [rba_pkg::ACC_BITS-1:0]        acc_out
);
   import rba_pkg::*;

   rba_ctrl_type               ctrl1_ff, ctrl1_in;
   logic signed [COORD_BITS:0] dx_ff, dx_in;
   logic signed [COORD_BITS:0] dz_ff, dz_in;

   rba_ctrl_type               ctrl2_ff;
   logic signed [W-1:0]        x_ff, x_in, z_ff, z_in;
   logic [ACC_BITS-1:0]        acc_ff, acc_in;
   logic signed [W-1:0]        dx_ext, dz_ext;

   // Stage 1: exact offsets, one bit wider than the coordinates
   always_comb begin
      dx_in          = $signed({target_x[COORD_BITS-1], target_x})
                     - $signed({pos_x[COORD_BITS-1], pos_x});
      dz_in          = $signed({target_z[COORD_BITS-1], target_z})
                     - $signed({pos_z[COORD_BITS-1], pos_z});
      ctrl1_in.valid = in_valid;
      ctrl1_in.zero  = (target_x == pos_x) && (target_z == pos_z);
   end

   // Stage 2: negate both offsets when dx is negative
   always_comb begin
      dx_ext = {{(W-COORD_BITS-1){dx_ff[COORD_BITS]}}, dx_ff};
      dz_ext = {{(W-COORD_BITS-1){dz_ff[COORD_BITS]}}, dz_ff};
      if (dx_ff[COORD_BITS]) begin
         x_in   = -dx_ext;
         z_in   = -dz_ext;
         acc_in = HALF_TURN;
      end else begin
         x_in   = dx_ext;
         z_in   = dz_ext;
         acc_in = '0;
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
      end else if (advance) begin
         ctrl1_ff <= ctrl1_in;
         ctrl2_ff <= ctrl1_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff  <= dx_in;
         dz_ff  <= dz_in;
         x_ff   <= x_in;
         z_ff   <= z_in;
         acc_ff <= acc_in;
      end
   end

   assign ctrl_out = ctrl2_ff;
   assign x_out    = x_ff;
   assign z_out    = z_ff;
   assign acc_out  = acc_ff;

endmodule
`default_nettype wire

FILE: rtl/rba_cordic_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rba_cordic_stage
// One registered vectoring micro-rotation: steers z toward zero and adds or
// subtracts atan(2^-STEP) to the angle accumulator.
// ----------------------------------------------------------------------------
module rba_cordic_stage #(
   parameter int W    = 35,
   parameter int STEP = 0
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire rba_pkg::rba_ctrl_type          ctrl_in,
   input  wire logic signed [W-1:0]            x_in,
   input  wire logic signed [W-1:0]            z_in,
   input  wire logic [rba_pkg::ACC_BITS-1:0]   acc_in,
   output rba_pkg::rba_ctrl_type               ctrl_out,
   output logic signed [W-1:0]                 x_out,
   output logic signed [W-1:0]                 z_out,
   output logic [rba_pkg::ACC_BITS-1:0]        acc_out
);
   import rba_pkg::*;

   rba_ctrl_type        ctrl_ff;
   logic signed [W-1:0] x_ff, x_next_in, z_ff, z_next_in;
   logic [ACC_BITS-1:0] acc_ff, acc_next_in;
   logic signed [W-1:0] xs, zs;
   logic                z_pos;

   // Micro-rotation; shifts floor toward minus infinity
   always_comb begin
      xs    = x_in >>> STEP;
      zs    = z_in >>> STEP;
      z_pos = !z_in[W-1] && (|z_in);
      if (z_pos) begin
         x_next_in   = x_in + zs;
         z_next_in   = z_in - xs;
         acc_next_in = acc_in + ATAN_TAB[STEP];
      end else begin
         x_next_in   = x_in - zs;
         z_next_in   = z_in + xs;
         acc_next_in = acc_in - ATAN_TAB[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff   <= x_next_in;
         z_ff   <= z_next_in;
         acc_ff <= acc_next_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign x_out    = x_ff;
   assign z_out    = z_ff;
   assign acc_out  = acc_ff;

endmodule
`default_nettype wire

FILE: rtl/rba_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rba_back
// Rounds the bearing to the output angle width, subtracts it from the
// heading and holds results in a two-entry output buffer (main + skid).
// ----------------------------------------------------------------------------
module rba_back #(
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rba_pkg::rba_ctrl_type          ctrl_in,
   input  wire logic [rba_pkg::ACC_BITS-1:0]   acc_in,
   input  wire logic signed [ANGLE_BITS-1:0]   heading,
   output logic                                advance,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [ANGLE_BITS-1:0]        rsp_rel_angle
);
   import rba_pkg::*;

   localparam logic [ACC_BITS-1:0] ROUND_BIAS = 32'd1 << (ACC_BITS - 1 - ANGLE_BITS);

   logic [ACC_BITS-1:0]   acc_rnd;
   logic [ANGLE_BITS-1:0] phi;
   logic [ANGLE_BITS-1:0] rel;
   logic                  push, pop;

   logic                  main_valid_ff, main_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [ANGLE_BITS-1:0] main_data_ff, main_data_in;
   logic [ANGLE_BITS-1:0] skid_data_ff, skid_data_in;

   // Round half-up to the output angle unit, then heading minus bearing
   always_comb begin
      acc_rnd = acc_in + ROUND_BIAS;
      phi     = acc_rnd[ACC_BITS-1 -: ANGLE_BITS];
      rel     = ctrl_in.zero ? '0 : (heading - phi);
   end

   // Pipeline moves only while the skid entry is free
   assign advance = !skid_valid_ff;
   assign push    = advance && ctrl_in.valid;
   assign pop     = main_valid_ff && !rsp_stall;

   // Output buffer next state
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = rel;
         end
      end else if (!main_valid_ff) begin
         main_valid_in = push;
         main_data_in  = rel;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = rel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid     = main_valid_ff;
   assign rsp_rel_angle = main_data_ff;

endmodule
`default_nettype wire

FILE: rtl/relative_bearing_angle.sv
`default_nettype none
// ----------------------------------------------------------------------------
// relative_bearing_angle
// Signed angle from the object's heading to the direction of a target point,
// heading minus atan2(dz, dx), in binary angle units wrapped to one turn.
//
// Usage:
//   csr_*  : write pos_x (index 0), pos_z (index 1) and heading (index 2)
//            while no transaction is in flight; other indexes are ignored.
//   req_*  : one target point per transaction, taken when req_valid is high
//            and req_stall is low.
//   rsp_*  : one rel_angle per request, in request order; the receiver holds
//            a result with rsp_stall.
// Pipeline: offset stage, fold stage, one stage per CORDIC micro-rotation,
//   output register.
// Throughput: one transaction per cycle while req_stall is low; each
//   micro-rotation has its own pipeline stage.
// Stall: a two-entry output buffer absorbs the result in flight; req_stall
//   rises from a register only when both entries are full.
// Reset: clears all valid bits and the CSR registers to zero.
// ----------------------------------------------------------------------------
module relative_bearing_angle #(
   parameter int COORD_BITS   = 32,
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // CSR write port
   input  wire logic                                    csr_we,
   input  wire logic [rba_pkg::CSR_ADDR_BITS-1:0]       csr_addr,
   input  wire logic [((COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS)-1:0]
                                                        csr_wdata,
   // Request channel
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic signed [COORD_BITS-1:0]            req_target_x,
   input  wire logic signed [COORD_BITS-1:0]            req_target_z,
   // Response channel
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [ANGLE_BITS-1:0]                 rsp_rel_angle
);
   import rba_pkg::*;

   // Datapath width covers CORDIC gain on a vector of up to sqrt(2)*2^COORD_BITS
   localparam int W = COORD_BITS + 3;

   logic signed [COORD_BITS-1:0] pos_x_ff, pos_z_ff;
   logic signed [ANGLE_BITS-1:0] heading_ff;
   logic                         advance;

   rba_ctrl_type        st_ctrl [CORDIC_STEPS+1];
   logic signed [W-1:0] st_x    [CORDIC_STEPS+1];
   logic signed [W-1:0] st_z    [CORDIC_STEPS+1];
   logic [ACC_BITS-1:0] st_acc  [CORDIC_STEPS+1];

   // CSR registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_z_ff   <= '0;
         heading_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_POS_X:   pos_x_ff   <= csr_wdata[COORD_BITS-1:0];
            CSR_POS_Z:   pos_z_ff   <= csr_wdata[COORD_BITS-1:0];
            CSR_HEADING: heading_ff <= csr_wdata[ANGLE_BITS-1:0];
            default:     ;
         endcase
      end
   end

   assign req_stall = !advance;

   // Offset and fold
   rba_front #(
      .COORD_BITS (COORD_BITS),
      .W          (W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .target_x (req_target_x),
      .target_z (req_target_z),
      .pos_x    (pos_x_ff),
      .pos_z    (pos_z_ff),
      .ctrl_out (st_ctrl[0]),
      .x_out    (st_x[0]),
      .z_out    (st_z[0]),
      .acc_out  (st_acc[0])
   );

   // CORDIC micro-rotation stages
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      rba_cordic_stage #(
         .W    (W),
         .STEP (i)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .ctrl_in  (st_ctrl[i]),
         .x_in     (st_x[i]),
         .z_in     (st_z[i]),
         .acc_in   (st_acc[i]),
         .ctrl_out (st_ctrl[i+1]),
         .x_out    (st_x[i+1]),
         .z_out    (st_z[i+1]),
         .acc_out  (st_acc[i+1])
      );
   end

   // Final x and z magnitudes are not needed past the last rotation
   rba_back #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .ctrl_in       (st_ctrl[CORDIC_STEPS]),
      .acc_in        (st_acc[CORDIC_STEPS]),
      .heading       (heading_ff),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rel_angle (rsp_rel_angle)
   );

   // Assertions
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result held");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (req_stall && rsp_stall) |=> req_stall)
      else $error("output buffer drained while receiver stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("buffer not empty after reset");

endmodule
`default_nettype wire
